>>> rtl/pfur_pkg.sv
// Shared constants, codes and types of the firmware update frame receiver.
package pfur_pkg;

   // Frame geometry
   localparam int DATA_BYTES = 128;
   localparam int NWORDS     = (DATA_BYTES + 7) / 8;
   localparam int IDX_W      = $clog2(DATA_BYTES);
   localparam int WADDR_W    = IDX_W - 3;
   localparam int COUNT_CAP  = DATA_BYTES + 5;
   localparam int CNT_W      = $clog2(COUNT_CAP + 1);
   localparam int WORD_W     = 64;

   // Frame positions and limits
   localparam logic [CNT_W-1:0] POS_FIRST = CNT_W'(0);
   localparam logic [CNT_W-1:0] POS_PN_LO = CNT_W'(1);
   localparam logic [CNT_W-1:0] POS_PN_HI = CNT_W'(2);
   localparam logic [CNT_W-1:0] POS_DATA  = CNT_W'(3);
   localparam logic [CNT_W-1:0] POS_SUM   = CNT_W'(DATA_BYTES + 3);
   localparam logic [CNT_W-1:0] FRAME_LEN = CNT_W'(DATA_BYTES + 4);
   localparam logic [CNT_W-1:0] CNT_CAP   = CNT_W'(COUNT_CAP);

   localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NWORDS - 1);
   localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(DATA_BYTES - 1);
   localparam logic [2:0]         LAST_LANE = 3'd7;
   localparam logic [31:0]        WORD_STEP = 32'd8;
   localparam logic [31:0]        ADDR_STEP = 32'(DATA_BYTES);

   // Header codes
   localparam logic [7:0] HDR_SOH128 = 8'd1;
   localparam logic [7:0] HDR_SOH1K  = 8'd2;
   localparam logic [7:0] HDR_EOT    = 8'd4;

   // Register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_APP_BASE     = 2'd0;
   localparam logic [1:0] REG_BACKUP_BASE  = 2'd1;
   localparam logic [1:0] REG_START_TARGET = 2'd2;

   // Stream widths
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 136;

   typedef enum logic [1:0] {
      REPLY_NONE = 2'd0,
      REPLY_ACK  = 2'd1,
      REPLY_NAK  = 2'd2
   } reply_type;

   typedef enum logic [1:0] {
      ST_RECV,
      ST_READ,
      ST_SHOW
   } state_type;

   // Result beat, lowest field last
   typedef struct packed {
      logic [2:0]        pad;
      logic [31:0]       update_total;
      logic              target_is_app;
      logic              region_switched;
      logic [WORD_W-1:0] write_data;
      logic [31:0]       write_address;
      logic              write_valid;
      reply_type         reply_code;
   } rsp_payload_type;

endpackage

>>> rtl/pfur_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pfur_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/packet_firmware_update_receiver.sv
// Firmware update frame receiver: frame check, data buffer and flash word drain.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_tvalid/tready   | req_tdata rx_byte, req_tlast frame_end
//  rsp     | out       | rsp_tvalid/tready   | rsp_tdata result fields, rsp_tlast last
//  csr     | in        | psel/penable/pready | three registers at 4*i, pready always high
//
// One byte is taken per cycle while the result register is free or being emptied.
// A frame that is written to flash drains 16 words from the word buffer RAM, each
// read in ST_READ and then presented in ST_SHOW, which waits out rsp stalls;
// no byte is taken during the drain. Every other frame end gives one beat at once.
// Reset is synchronous and clears all control state; the buffer RAM is not cleared.
module packet_firmware_update_receiver (
   input  logic                                 clock,
   input  logic                                 reset,
   // byte stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pfur_pkg::REQ_TDATA_W-1:0]     req_tdata,  // [7:0] rx_byte
   input  logic                                 req_tlast,
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [1:0] reply_code, [2] write_valid, [34:3] write_address, [98:35] write_data,
   // [99] region_switched, [100] target_is_app, [132:101] update_total, [135:133] 0
   output logic [pfur_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast,
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pfur_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [pfur_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [pfur_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   import pfur_pkg::*;

   // Registers
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      byte_count_ff, byte_count_in;
   logic [7:0]            first_byte_ff, first_byte_in;
   logic [15:0]           pn_ff, pn_in;
   logic [7:0]            run_sum_ff, run_sum_in;
   logic [7:0]            sum_byte_ff, sum_byte_in;
   logic [15:0]           prev_num_ff, prev_num_in;
   logic                  target_ff, target_in;
   logic [31:0]           upd_count_ff, upd_count_in;
   logic [31:0]           app_base_ff, app_base_in;
   logic [31:0]           backup_base_ff, backup_base_in;
   logic                  start_ff, start_in;
   logic [31:0]           offset_ff, offset_in;
   logic [WORD_W-1:0]     asm_ff, asm_in;
   logic [31:0]           addr_ff, addr_in;
   logic [WADDR_W-1:0]    word_ff, word_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_last_ff, rsp_last_in;
   rsp_payload_type       rsp_ff, rsp_in;

   // Combinational signals
   logic                  out_free;
   logic                  req_acc;
   logic                  csr_wr;
   logic                  ram_rd_en;
   logic                  show_load;
   logic                  ram_wr_en;
   logic [WORD_W-1:0]     ram_rd_data;
   logic [IDX_W-1:0]      data_idx;
   logic [2:0]            lane;
   logic [WADDR_W-1:0]    wr_word;
   logic                  is_eot;
   logic                  frame_bad;
   logic                  drain_start;
   logic                  single_load;
   reply_type             single_code;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   assign data_idx = IDX_W'(byte_count_ff - POS_DATA);
   assign lane     = data_idx[2:0];
   assign wr_word  = data_idx[IDX_W-1:3];

   // Word buffer
   pfur_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NWORDS)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_word),
      .wr_data (asm_in),
      .rd_en   (ram_rd_en),
      .rd_addr (word_ff),
      .rd_data (ram_rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RECV: begin
            if (drain_start) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (out_free) begin
               state_in = (word_ff == LAST_WORD) ? ST_RECV : ST_READ;
            end
         end
         default: begin
            state_in = ST_RECV;
         end
      endcase
   end

   // State outputs
   always_comb begin
      req_tready = 1'b0;
      ram_rd_en  = 1'b0;
      show_load  = 1'b0;
      unique case (state_ff)
         ST_RECV: req_tready = out_free;
         ST_READ: ram_rd_en  = 1'b1;
         ST_SHOW: show_load  = out_free;
         default: req_tready = 1'b0;
      endcase
   end

   // Frame parsing, judgement and persistent state
   always_comb begin
      byte_count_in  = byte_count_ff;
      first_byte_in  = first_byte_ff;
      pn_in          = pn_ff;
      run_sum_in     = run_sum_ff;
      sum_byte_in    = sum_byte_ff;
      prev_num_in    = prev_num_ff;
      target_in      = target_ff;
      upd_count_in   = upd_count_ff;
      offset_in      = offset_ff;
      asm_in         = asm_ff;
      app_base_in    = app_base_ff;
      backup_base_in = backup_base_ff;
      start_in       = start_ff;
      addr_in        = addr_ff;
      word_in        = word_ff;
      ram_wr_en      = 1'b0;
      is_eot         = 1'b0;
      frame_bad      = 1'b0;
      drain_start    = 1'b0;
      single_load    = 1'b0;
      single_code    = REPLY_NONE;

      if (req_acc) begin
         // store the byte by its frame position
         if (byte_count_ff == POS_FIRST) begin
            first_byte_in = req_tdata;
         end else if (byte_count_ff == POS_PN_LO) begin
            pn_in = {pn_ff[15:8], req_tdata};
         end else if (byte_count_ff == POS_PN_HI) begin
            pn_in     = {req_tdata, pn_ff[7:0]};
            offset_in = ({16'h0, pn_in} - 32'd1) * ADDR_STEP;
         end else if (byte_count_ff < POS_SUM) begin
            // assemble the flash word, clearing it at its first byte
            for (int l = 0; l < 8; l++) begin
               if (3'(l) == lane) begin
                  asm_in[8*l +: 8] = req_tdata;
               end else if (lane == 3'd0) begin
                  asm_in[8*l +: 8] = 8'h00;
               end
            end
            ram_wr_en  = (lane == LAST_LANE) || (data_idx == LAST_IDX);
            run_sum_in = run_sum_ff + req_tdata;
         end else if (byte_count_ff == POS_SUM) begin
            sum_byte_in = req_tdata;
         end
         if (byte_count_ff != CNT_CAP) begin
            byte_count_in = byte_count_ff + CNT_W'(1);
         end

         // judge the frame on its last byte
         if (req_tlast) begin
            is_eot    = (first_byte_in == HDR_EOT);
            frame_bad = !((first_byte_in == HDR_SOH128) || (first_byte_in == HDR_SOH1K))
                        || (byte_count_in != FRAME_LEN) || (run_sum_in != sum_byte_in);
            priority if (is_eot) begin
               upd_count_in = upd_count_ff + 32'd1;
               target_in    = !target_ff;
               single_load  = 1'b1;
               single_code  = REPLY_ACK;
            end else if (frame_bad) begin
               single_load = 1'b1;
               single_code = REPLY_NAK;
            end else if (pn_in == prev_num_ff) begin
               single_load = 1'b1;
               single_code = REPLY_NONE;
            end else begin
               drain_start = 1'b1;
               prev_num_in = pn_in;
               addr_in     = (target_ff ? app_base_ff : backup_base_ff) + offset_ff;
               word_in     = '0;
            end
            // drop the frame state
            byte_count_in = '0;
            first_byte_in = 8'h00;
            pn_in         = 16'h0000;
            run_sum_in    = 8'h00;
            sum_byte_in   = 8'h00;
         end
      end

      // advance the drain
      if (show_load) begin
         addr_in = addr_ff + WORD_STEP;
         word_in = word_ff + WADDR_W'(1);
      end

      // register writes
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_APP_BASE:     app_base_in    = csr_pwdata;
            REG_BACKUP_BASE:  backup_base_in = csr_pwdata;
            REG_START_TARGET: begin
               start_in  = csr_pwdata[0];
               target_in = csr_pwdata[0];
            end
            default: start_in = start_ff;
         endcase
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (single_load) begin
         rsp_valid_in           = 1'b1;
         rsp_last_in            = 1'b1;
         rsp_in.pad             = 3'b000;
         rsp_in.update_total    = upd_count_in;
         rsp_in.target_is_app   = target_in;
         rsp_in.region_switched = is_eot;
         rsp_in.write_data      = '0;
         rsp_in.write_address   = 32'h0;
         rsp_in.write_valid     = 1'b0;
         rsp_in.reply_code      = single_code;
      end else if (show_load) begin
         rsp_valid_in           = 1'b1;
         rsp_last_in            = (word_ff == LAST_WORD);
         rsp_in.pad             = 3'b000;
         rsp_in.update_total    = upd_count_ff;
         rsp_in.target_is_app   = target_ff;
         rsp_in.region_switched = 1'b0;
         rsp_in.write_data      = ram_rd_data;
         rsp_in.write_address   = addr_ff;
         rsp_in.write_valid     = 1'b1;
         if (word_ff == LAST_WORD) begin
            rsp_in.reply_code = REPLY_ACK;
         end else begin
            rsp_in.reply_code = REPLY_NONE;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_RECV;
         byte_count_ff  <= '0;
         first_byte_ff  <= 8'h00;
         pn_ff          <= 16'h0000;
         run_sum_ff     <= 8'h00;
         sum_byte_ff    <= 8'h00;
         prev_num_ff    <= 16'h0000;
         target_ff      <= 1'b0;
         upd_count_ff   <= 32'h0;
         app_base_ff    <= 32'h0;
         backup_base_ff <= 32'h0;
         start_ff       <= 1'b0;
         word_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         byte_count_ff  <= byte_count_in;
         first_byte_ff  <= first_byte_in;
         pn_ff          <= pn_in;
         run_sum_ff     <= run_sum_in;
         sum_byte_ff    <= sum_byte_in;
         prev_num_ff    <= prev_num_in;
         target_ff      <= target_in;
         upd_count_ff   <= upd_count_in;
         app_base_ff    <= app_base_in;
         backup_base_ff <= backup_base_in;
         start_ff       <= start_in;
         word_ff        <= word_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      offset_ff   <= offset_in;
      asm_ff      <= asm_in;
      addr_ff     <= addr_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ff      <= rsp_in;
   end

   // Register read-back
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_APP_BASE:     csr_prdata = app_base_ff;
         REG_BACKUP_BASE:  csr_prdata = backup_base_ff;
         REG_START_TARGET: csr_prdata = {31'h0, start_ff};
         default:          csr_prdata = 32'h0;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

>>> tb/update_frame_checker.sv
// Checker for the update frame receiver: predicts every result beat and compares it on delivery.
module update_frame_checker
   import pfur_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [REQ_TDATA_W-1:0]     req_tdata,   // [7:0] rx_byte
   input  logic                       req_tlast,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [RSP_TDATA_W-1:0]     rsp_tdata,   // fields as in rsp_payload_type
   input  logic                       rsp_tlast,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [CSR_DATA_W-1:0]      csr_pwdata,
   input  logic                       csr_pready,
   output int                         fail_count,
   output int                         results_due
);

   typedef struct {
      rsp_payload_type body;
      logic            last;
   } flash_beat_t;

   // predicted beats, oldest first
   flash_beat_t      due_beats[$];

   // register copies
   logic [31:0]      app_base;
   logic [31:0]      backup_base;

   // frame under reception
   logic [CNT_W-1:0] frame_pos;
   logic [7:0]       head_byte;
   logic [15:0]      pkt_num;
   logic [7:0]       data_sum;
   logic [7:0]       sum_field;
   logic [7:0]       frame_data [DATA_BYTES];

   // state kept across frames
   logic [15:0]      last_pkt;
   logic             region_app;
   logic [31:0]      updates;
   int               miss_total = 0;

   task check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
         miss_total++;
      end
   endtask

   // a frame end that writes no flash word
   function automatic flash_beat_t plain_reply(input reply_type code, input logic switched);
      flash_beat_t beat;
      beat.body = '0;
      beat.body.reply_code = code;
      beat.body.region_switched = switched;
      beat.body.target_is_app = region_app;
      beat.body.update_total = updates;
      beat.last = 1'b1;
      return beat;
   endfunction

   always @(posedge clock) begin : watch
      flash_beat_t     want;
      flash_beat_t     beat;
      rsp_payload_type got;
      logic [7:0]      b;
      logic [31:0]     base;
      logic [31:0]     addr;
      logic [63:0]     word;
      int              idx;
      int              k;
      int              j;
      if (reset) begin
         app_base = '0;
         backup_base = '0;
         frame_pos = '0;
         head_byte = '0;
         pkt_num = '0;
         data_sum = '0;
         sum_field = '0;
         last_pkt = '0;
         region_app = 1'b0;
         updates = '0;
         due_beats.delete();
      end else begin
         // compare each delivered beat with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (due_beats.size() == 0) begin
               $display("%0t result beat with nothing predicted: %0h", $time, rsp_tdata);
               miss_total++;
            end else begin
               want = due_beats.pop_front();
               check_field("reply_code", 64'(want.body.reply_code), 64'(got.reply_code));
               check_field("write_valid", 64'(want.body.write_valid), 64'(got.write_valid));
               check_field("write_address", 64'(want.body.write_address),
                           64'(got.write_address));
               check_field("write_data", want.body.write_data, got.write_data);
               check_field("region_switched", 64'(want.body.region_switched),
                           64'(got.region_switched));
               check_field("target_is_app", 64'(want.body.target_is_app),
                           64'(got.target_is_app));
               check_field("update_total", 64'(want.body.update_total), 64'(got.update_total));
               check_field("pad", 64'(want.body.pad), 64'(got.pad));
               check_field("last", 64'(want.last), 64'(rsp_tlast));
            end
         end

         // track register writes; the start target also reloads the live target
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_APP_BASE:     app_base = csr_pwdata;
               REG_BACKUP_BASE:  backup_base = csr_pwdata;
               REG_START_TARGET: region_app = csr_pwdata[0];
               default: ;
            endcase
         end

         // absorb a byte into the frame
         if (req_tvalid && req_tready) begin
            b = req_tdata[7:0];
            if (frame_pos == POS_FIRST) begin
               head_byte = b;
            end else if (frame_pos == POS_PN_LO) begin
               pkt_num[7:0] = b;
            end else if (frame_pos == POS_PN_HI) begin
               pkt_num[15:8] = b;
            end else if (frame_pos < POS_SUM) begin
               frame_data[frame_pos - POS_DATA] = b;
               data_sum = data_sum + b;
            end else if (frame_pos == POS_SUM) begin
               sum_field = b;
            end
            // saturate the position on overlong frames
            if (frame_pos < CNT_CAP) frame_pos = frame_pos + 1'b1;

            // judge the frame on its final byte
            if (req_tlast) begin
               if (head_byte == HDR_EOT) begin
                  updates = updates + 32'd1;
                  region_app = !region_app;
                  due_beats.push_back(plain_reply(REPLY_ACK, 1'b1));
               end else if ((head_byte != HDR_SOH128 && head_byte != HDR_SOH1K) ||
                            frame_pos != FRAME_LEN || data_sum != sum_field) begin
                  due_beats.push_back(plain_reply(REPLY_NAK, 1'b0));
               end else if (pkt_num == last_pkt) begin
                  due_beats.push_back(plain_reply(REPLY_NONE, 1'b0));
               end else begin
                  base = region_app ? app_base : backup_base;
                  addr = base + (32'(pkt_num) - 32'd1) * ADDR_STEP;
                  for (k = 0; k < NWORDS; k++) begin
                     word = '0;
                     for (j = 0; j < 8; j++) begin
                        idx = k * 8 + j;
                        if (idx < DATA_BYTES) word[j*8 +: 8] = frame_data[idx];
                     end
                     beat.body = '0;
                     beat.body.reply_code = (k == NWORDS - 1) ? REPLY_ACK : REPLY_NONE;
                     beat.body.write_valid = 1'b1;
                     beat.body.write_address = addr + 32'(k) * WORD_STEP;
                     beat.body.write_data = word;
                     beat.body.target_is_app = region_app;
                     beat.body.update_total = updates;
                     beat.last = (k == NWORDS - 1);
                     due_beats.push_back(beat);
                  end
                  last_pkt = pkt_num;
               end
               frame_pos = '0;
               head_byte = '0;
               pkt_num = '0;
               data_sum = '0;
               sum_field = '0;
            end
         end
      end
      fail_count <= miss_total;
      results_due <= due_beats.size();
   end

endmodule

>>> tb/tb_top.sv
// Top of the update frame receiver bench: clock, reset, register set-up, frame stimulus, verdict.
module tb_top;
   import pfur_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 40;
   localparam int LONG_HOLD   = 300;

   typedef enum int {
      FR_WRITE,
      FR_REPEAT,
      FR_BAD_SUM,
      FR_BAD_HEAD,
      FR_SHORT,
      FR_LONG,
      FR_EOT,
      FR_NOISE
   } frame_kind_type;

   typedef enum int {
      RX_OPEN,
      RX_BUSY_LIGHT,
      RX_BUSY_HEAVY,
      RX_PERIODIC
   } rx_mode_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata;    // [7:0] rx_byte
   logic                    req_tlast;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;    // [1:0] reply_code .. [132:101] update_total
   logic                    rsp_tlast;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   int                      fail_count;
   int                      results_due;
   int                      cycle_count = 0;
   int                      bytes_sent = 0;
   int                      results_made = 0;
   int                      burst_left = 0;
   int                      write_frames = 0;
   bit                      hold_off_ask = 1'b0;
   logic [15:0]             last_pkt = '0;
   logic [7:0]              frame_bytes[$];

   packet_firmware_update_receiver dut (.*);
   update_frame_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // end the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver: change stall mode now and then, honour one long hold-off
   initial begin : receiver
      rx_mode_type mode;
      int          mode_left;
      int          tick;
      rsp_tready = 1'b0;
      mode = RX_OPEN;
      mode_left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (hold_off_ask) begin
            hold_off_ask = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 120);
            end
            mode_left--;
            tick++;
            case (mode)
               RX_OPEN:       rsp_tready <= 1'b1;
               RX_BUSY_LIGHT: rsp_tready <= ($urandom_range(0, 3) != 0);
               RX_BUSY_HEAVY: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:       rsp_tready <= ((tick % 7) < 3);
            endcase
         end
      end
   end

   // offer one byte, with a random gap between bursts, and hold until it is taken
   task put_beat(input logic [7:0] b, input logic fin);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= fin;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      bytes_sent++;
   endtask

   task push_frame();
      foreach (frame_bytes[i]) put_beat(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // drop valid, wait for every predicted beat, then let the block settle
   task wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task csr_write(input logic [1:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({index, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task configure(input logic [31:0] app, input logic [31:0] backup, input logic start_app);
      csr_write(REG_APP_BASE, app);
      csr_write(REG_BACKUP_BASE, backup);
      csr_write(REG_START_TARGET, {31'd0, start_app});
   endtask

   // build a frame of the given kind with random content and send it
   task send_frame(input frame_kind_type kind);
      logic [7:0]  head;
      logic [15:0] pkt;
      logic [7:0]  check;
      logic [7:0]  d;
      int          fill;
      int          cut;
      frame_bytes.delete();
      head = $urandom_range(0, 1) ? HDR_SOH1K : HDR_SOH128;
      pkt = 16'($urandom);
      if (kind == FR_WRITE) begin
         // walk through the address wrap cases first
         case (write_frames)
            0:       pkt = 16'hFFFF;
            1:       pkt = 16'h0000;
            2:       pkt = 16'h0001;
            default: ;
         endcase
         write_frames++;
      end
      if (kind == FR_REPEAT) pkt = last_pkt;
      if (kind == FR_BAD_HEAD) begin
         do head = 8'($urandom);
         while (head == HDR_SOH128 || head == HDR_SOH1K || head == HDR_EOT);
      end
      fill = $urandom_range(0, 7);
      frame_bytes.push_back(head);
      frame_bytes.push_back(pkt[7:0]);
      frame_bytes.push_back(pkt[15:8]);
      check = '0;
      for (int i = 0; i < DATA_BYTES; i++) begin
         d = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
         check = check + d;
         frame_bytes.push_back(d);
      end
      if (kind == FR_BAD_SUM) check = check + 8'($urandom_range(1, 255));
      frame_bytes.push_back(check);

      case (kind)
         FR_SHORT: begin
            cut = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 128) : $urandom_range(1, 3);
            repeat (cut) frame_bytes.delete(frame_bytes.size() - 1);
         end
         FR_LONG: begin
            if ($urandom_range(0, 1)) frame_bytes[0] = HDR_EOT;
            repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
         end
         FR_EOT: begin
            frame_bytes.delete();
            frame_bytes.push_back(HDR_EOT);
            repeat ($urandom_range(0, 5)) frame_bytes.push_back(8'($urandom));
         end
         FR_NOISE: begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
         end
         default: ;
      endcase

      // tally results to know when enough have come
      if (kind == FR_WRITE && pkt != last_pkt) begin
         results_made += NWORDS;
         last_pkt = pkt;
      end else begin
         results_made += 1;
      end
      push_frame();
   endtask

   initial begin : stimulus
      int             phase;
      int             phase_bytes;
      int             phase_frames;
      int             pick;
      frame_kind_type kind;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      configure($urandom, $urandom, 1'b1);

      // short frames: end of transfer, bad headers, truncated packets
      frame_bytes = '{HDR_EOT};
      push_frame();
      frame_bytes = '{HDR_EOT, 8'hFF, 8'h00};
      push_frame();
      frame_bytes = '{8'h00};
      push_frame();
      frame_bytes = '{8'hFF};
      push_frame();
      frame_bytes = '{HDR_SOH128, 8'h01, 8'h00, 8'hAA};
      push_frame();
      frame_bytes = '{HDR_SOH1K, 8'hFF, 8'hFF};
      push_frame();
      frame_bytes = '{8'h03, 8'h80, 8'h7F, 8'h55};
      push_frame();
      frame_bytes = '{HDR_EOT};
      push_frame();
      results_made += 8;
      wait_idle();

      // random frames in phases, a fresh register setting for each
      for (phase = 0; phase < 2 || bytes_sent < 340 || results_made < 40; phase++) begin
         case (phase % 4)
            0:       configure(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
            1:       configure(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
            default: configure($urandom, $urandom, 1'($urandom_range(0, 1)));
         endcase
         phase_bytes = bytes_sent;
         phase_frames = 0;
         send_frame(FR_WRITE);
         // stall the receiver across the drain while the next frame is offered
         if (phase == 1) hold_off_ask = 1'b1;
         while (phase_frames < 1 || bytes_sent - phase_bytes < 140) begin
            pick = $urandom_range(0, 99);
            if (pick < 15)      kind = FR_WRITE;
            else if (pick < 20) kind = FR_REPEAT;
            else if (pick < 26) kind = FR_BAD_SUM;
            else if (pick < 30) kind = FR_BAD_HEAD;
            else if (pick < 38) kind = FR_SHORT;
            else if (pick < 44) kind = FR_LONG;
            else if (pick < 70) kind = FR_EOT;
            else                kind = FR_NOISE;
            send_frame(kind);
            phase_frames++;
         end
         wait_idle();
      end

      if (fail_count == 0 && results_due == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
